[rtl/core/ibp_pkg.sv]
`timescale 1ns / 1ps

package ibp_pkg;

    localparam int MAX_SIZE    = 64;
    localparam int SAMPLE_BITS = 10;
    localparam int STORE_DEPTH = 2 * MAX_SIZE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // index width: holds the store depth and block sizes up to 128
    localparam int IDX_W       = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;
    localparam int ACC_W       = SAMPLE_BITS + IDX_W;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_PREDICT = 1'b1;

    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_UP     = 2'd1;
    localparam logic [1:0] SIDE_CORNER = 2'd2;

    localparam logic [2:0] MODE_VER = 3'd0;
    localparam logic [2:0] MODE_HOR = 3'd1;
    localparam logic [2:0] MODE_DC  = 3'd2;
    localparam logic [2:0] MODE_UL  = 3'd3;
    localparam logic [2:0] MODE_UR  = 3'd4;

    typedef struct packed {
        logic                   operation;
        logic [1:0]             side;
        logic [6:0]             position;
        logic [SAMPLE_BITS-1:0] sample;
        logic [2:0]             mode;
        logic [2:0]             log2_width;
        logic [2:0]             log2_height;
        logic [5:0]             row;
        logic [5:0]             col;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pixel;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DC_WALK,
        S_DC_DRAIN,
        S_DC_DONE,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic dc_clear;
        logic dc_step;
        logic dc_finish;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic in_load;
        logic mode_ok;
        logic mode_dc;
        logic dc_hit;
        logic dc_last;
        logic out_free;
    } t_stat;

endpackage

[rtl/core/ibp_in_if.sv]
`timescale 1ns / 1ps

interface ibp_in_if import ibp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ibp_out_if.sv]
`timescale 1ns / 1ps

interface ibp_out_if import ibp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/ibp_ctrl.sv]
`timescale 1ns / 1ps

module ibp_ctrl import ibp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    // loads are written at the accept edge
                    n_state = i_stat.in_load ? S_IDLE : S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (!i_stat.mode_ok) begin
                    n_state = S_IDLE;
                end else if (i_stat.mode_dc && !i_stat.dc_hit) begin
                    o_cmd.dc_clear = 1'b1;
                    n_state = S_DC_WALK;
                end else begin
                    // pixel reads are issued in this cycle
                    n_state = S_PUSH;
                end
            end
            S_DC_WALK: begin
                o_cmd.dc_step = 1'b1;
                if (i_stat.dc_last) begin
                    n_state = S_DC_DRAIN;
                end
            end
            S_DC_DRAIN: begin
                n_state = S_DC_DONE;
            end
            S_DC_DONE: begin
                o_cmd.dc_finish = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_stat.out_free)
        else $error("result pushed into a full output register");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("ready raised while an item is in work");

    a_dc_to_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dc_finish |=> (r_state == S_PUSH))
        else $error("dc result not followed by push");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.dc_step && i_stat.dc_last) |=> (r_state == S_DC_DRAIN))
        else $error("dc walk did not stop at its last entry");

endmodule

[rtl/core/ibp_datapath.sv]
`timescale 1ns / 1ps

module ibp_datapath import ibp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  t_in_word               i_word,
    output t_stat                  o_stat,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [SAMPLE_BITS-1:0] o_out_pixel
);

    logic [SAMPLE_BITS-1:0] left_mem [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] up_mem   [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_corner;

    logic [2:0] r_mode;
    logic [2:0] r_lw;
    logic [2:0] r_lh;
    logic [5:0] r_row;
    logic [5:0] r_col;

    logic [SAMPLE_BITS-1:0] r_left_q;
    logic [SAMPLE_BITS-1:0] r_up_q;
    logic                   r_left_on;
    logic                   r_up_on;

    logic [IDX_W-1:0]       r_k;
    logic                   r_acc_en;
    logic [ACC_W-1:0]       r_acc;
    logic [SAMPLE_BITS-1:0] r_dc;
    logic                   r_dc_valid;
    logic [2:0]             r_dc_lw;
    logic [2:0]             r_dc_lh;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_pixel;

    logic [IDX_W-1:0]       row_x;
    logic [IDX_W-1:0]       col_x;
    logic [IDX_W-1:0]       pos_x;
    logic [IDX_W-1:0]       left_idx;
    logic [IDX_W-1:0]       up_idx;
    logic [IDX_W-1:0]       blk_w;
    logic [IDX_W-1:0]       blk_h;
    logic [2:0]             lmax;
    logic                   left_ok;
    logic                   up_ok;
    logic                   do_load;
    logic [SAMPLE_BITS-1:0] left_v;
    logic [SAMPLE_BITS-1:0] up_v;
    logic [SAMPLE_BITS:0]   ur_sum;
    logic [ACC_W-1:0]       dc_total;
    logic [ACC_W-1:0]       dc_shift;
    logic [SAMPLE_BITS-1:0] dc_val;
    logic [SAMPLE_BITS-1:0] pix_val;

    assign row_x = IDX_W'(r_row);
    assign col_x = IDX_W'(r_col);
    assign pos_x = IDX_W'(i_word.position);
    assign blk_w = IDX_W'(1) << r_lw;
    assign blk_h = IDX_W'(1) << r_lh;
    assign lmax  = (r_lw > r_lh) ? r_lw : r_lh;

    assign do_load = i_cmd.capture && (i_word.operation == OP_LOAD);

    // read addresses: dc walk counter, else the mode's neighbour position
    always_comb begin
        left_idx = row_x;
        up_idx   = col_x;
        if (i_cmd.dc_step) begin
            left_idx = r_k;
            up_idx   = r_k;
        end else begin
            priority case (r_mode)
                MODE_UL: begin
                    left_idx = row_x - col_x - IDX_W'(1);
                    up_idx   = col_x - row_x - IDX_W'(1);
                end
                MODE_UR: begin
                    left_idx = row_x + col_x + IDX_W'(1);
                    up_idx   = row_x + col_x + IDX_W'(1);
                end
                default: begin
                    left_idx = row_x;
                    up_idx   = col_x;
                end
            endcase
        end
    end

    assign left_ok = (left_idx < IDX_W'(STORE_DEPTH)) &&
                     (!i_cmd.dc_step || (r_k < blk_h));
    assign up_ok   = (up_idx < IDX_W'(STORE_DEPTH)) &&
                     (!i_cmd.dc_step || (r_k < blk_w));

    always_ff @(posedge i_clk) begin
        if (do_load && (i_word.side == SIDE_LEFT) && (pos_x < IDX_W'(STORE_DEPTH))) begin
            left_mem[pos_x[ADDR_W-1:0]] <= i_word.sample;
        end
        if (do_load && (i_word.side == SIDE_UP) && (pos_x < IDX_W'(STORE_DEPTH))) begin
            up_mem[pos_x[ADDR_W-1:0]] <= i_word.sample;
        end
        r_left_q <= left_mem[left_idx[ADDR_W-1:0]];
        r_up_q   <= up_mem[up_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_left_on <= left_ok;
        r_up_on   <= up_ok;
        if (do_load && (i_word.side == SIDE_CORNER)) begin
            r_corner <= i_word.sample;
        end
        if (i_cmd.capture) begin
            r_mode <= i_word.mode;
            r_lw   <= i_word.log2_width;
            r_lh   <= i_word.log2_height;
            r_row  <= i_word.row;
            r_col  <= i_word.col;
        end
    end

    assign left_v = r_left_on ? r_left_q : '0;
    assign up_v   = r_up_on ? r_up_q : '0;

    // dc: (sum + w) >> (log2 w + 1), saturated
    assign dc_total = r_acc + (ACC_W'(1) << r_lw);
    assign dc_shift = dc_total >> ({1'b0, r_lw} + 4'd1);
    assign dc_val   = (dc_shift > ACC_W'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                      : dc_shift[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.dc_clear) begin
            r_k   <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.dc_step) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (r_acc_en) begin
                r_acc <= r_acc + ACC_W'(left_v) + ACC_W'(up_v);
            end
        end
        if (i_cmd.dc_finish) begin
            r_dc    <= dc_val;
            r_dc_lw <= r_lw;
            r_dc_lh <= r_lh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en   <= 1'b0;
            r_dc_valid <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.dc_step;
            // any edge write makes the cached dc stale
            if (do_load && ((i_word.side == SIDE_LEFT) || (i_word.side == SIDE_UP))) begin
                r_dc_valid <= 1'b0;
            end else if (i_cmd.dc_finish) begin
                r_dc_valid <= 1'b1;
            end
        end
    end

    assign ur_sum = {1'b0, left_v} + {1'b0, up_v};

    always_comb begin
        unique case (r_mode)
            MODE_VER: pix_val = up_v;
            MODE_HOR: pix_val = left_v;
            MODE_DC:  pix_val = r_dc;
            MODE_UL: begin
                priority if (r_row > r_col) begin
                    pix_val = left_v;
                end else if (r_row == r_col) begin
                    pix_val = r_corner;
                end else begin
                    pix_val = up_v;
                end
            end
            MODE_UR:  pix_val = ur_sum[SAMPLE_BITS:1];
            default:  pix_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_pixel <= pix_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pixel = r_out_pixel;

    assign o_stat.in_load  = (i_word.operation == OP_LOAD);
    assign o_stat.mode_ok  = (r_mode <= MODE_UR);
    assign o_stat.mode_dc  = (r_mode == MODE_DC);
    assign o_stat.dc_hit   = r_dc_valid && (r_dc_lw == r_lw) && (r_dc_lh == r_lh);
    assign o_stat.dc_last  = ((r_k + IDX_W'(1)) == (IDX_W'(1) << lmax));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    a_acc_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dc_step |=> r_acc_en)
        else $error("dc read not accumulated");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && !i_cmd.push) |=> $stable(r_out_pixel))
        else $error("stalled result changed");

    a_dc_cache_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dc_finish && !do_load) |=> r_dc_valid)
        else $error("dc cache not marked after finish");

endmodule

[rtl/core/intra_block_predictor.sv]
`timescale 1ns / 1ps
// intra block predictor: one predicted pixel per predict word of a valid mode
// channels: i_in carries load and predict words, o_out carries pixel words,
//   both valid/ready, a word moves on a clock edge with valid and ready high
// a load word writes the left, up or corner store at its accept edge and
//   gives no result; the block takes the next word in the following cycle
// a predict word for vertical, horizontal or the diagonals goes through the
//   decode state (registered reads of the two sample memories) and the push
//   state (mode select into the output register), then frees the input
// dc walks both memories in parallel, one entry a cycle, over 2^max(lw,lh)
//   entries, then goes through the drain, done and push states; the dc value
//   is kept and reused by later dc words of the same size until a left or up
//   sample is written, and such a reuse goes straight to push like the other modes
// a predict word with a mode above four is accepted and dropped
// one word is in work at a time; ready is low until its result is in the
//   output register or it is dropped; that register holds while the receiver
//   stalls, and a finished item waits in the push state for room
// reset (synchronous, active low) empties the output register, clears the
//   dc cache and returns the controller to idle; the sample stores are not
//   cleared and must be loaded before they are read

module intra_block_predictor import ibp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ibp_in_if.sink     i_in,
    ibp_out_if.source  o_out
);

    t_cmd  cmd;
    t_stat stat;

    ibp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ibp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_word      (i_in.data),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_pixel (o_out.data.pixel)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ibp_pkg::*;

    localparam int          ITEMS        = 1800;
    localparam int          TAIL_CYCLES  = 200;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    typedef struct {
        t_in_word               word;
        bit                     typed;
        logic [SAMPLE_BITS-1:0] pixel;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ibp_in_if  in_if();
    ibp_out_if out_if();

    intra_block_predictor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the neighbour stores
    logic [SAMPLE_BITS-1:0] left_store [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] up_store [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] corner_store;

    logic [SAMPLE_BITS-1:0] pending_pixels[$];

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned words_counted = 0;
    int unsigned loads_sent    = 0;
    int unsigned predicts_sent = 0;
    int unsigned dropped_sent  = 0;
    int unsigned pixels_seen   = 0;
    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;

    task automatic report_mismatch(input string what);
        if (error_count < 50)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // idle draws pause at the start of each period of the cycle counter for a clean stretch
    function automatic bit idle_now(input int pct);
        return ((cycle_count % 200) >= 30) && ($urandom_range(99) < pct);
    endfunction

    function automatic t_in_word mk_load(input logic [1:0] side, input int pos, input int smp);
        t_in_word w;
        w = $bits(t_in_word)'({$urandom, $urandom});
        w.operation = OP_LOAD;
        w.side      = side;
        w.position  = 7'(pos);
        w.sample    = SAMPLE_BITS'(smp);
        return w;
    endfunction

    function automatic t_in_word mk_pred(input logic [2:0] mode, input int lw, input int lh,
                                         input int r, input int c);
        t_in_word w;
        w = $bits(t_in_word)'({$urandom, $urandom});
        w.operation   = OP_PREDICT;
        w.mode        = mode;
        w.log2_width  = 3'(lw);
        w.log2_height = 3'(lh);
        w.row         = 6'(r);
        w.col         = 6'(c);
        return w;
    endfunction

    function automatic bit predict_pixel(input t_in_word w, output logic [SAMPLE_BITS-1:0] px);
        int unsigned r;
        int unsigned c;
        int unsigned acc;
        r   = 32'(w.row);
        c   = 32'(w.col);
        acc = 0;
        px  = '0;
        case (w.mode)
            MODE_VER: px = up_store[ADDR_W'(c)];
            MODE_HOR: px = left_store[ADDR_W'(r)];
            MODE_DC: begin
                for (int k = 0; k < (1 << w.log2_height); k++)
                    acc += 32'(left_store[ADDR_W'(k)]);
                for (int k = 0; k < (1 << w.log2_width); k++)
                    acc += 32'(up_store[ADDR_W'(k)]);
                acc = (acc + (1 << w.log2_width)) >> (w.log2_width + 1);
                px  = (acc > SAMPLE_MAX) ? SAMPLE_MAX : acc[SAMPLE_BITS-1:0];
            end
            MODE_UL: begin
                if (r > c)
                    px = left_store[ADDR_W'(r - c - 1)];
                else if (r == c)
                    px = corner_store;
                else
                    px = up_store[ADDR_W'(c - r - 1)];
            end
            MODE_UR: begin
                acc = 32'(up_store[ADDR_W'(r + c + 1)]) + 32'(left_store[ADDR_W'(r + c + 1)]);
                px  = SAMPLE_BITS'(acc >> 1);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // update the store copy or queue the expected pixel for one accepted word
    task automatic apply_word(input t_in_word w, input bit typed,
                              input logic [SAMPLE_BITS-1:0] typed_px);
        logic [SAMPLE_BITS-1:0] px;
        if (w.operation == OP_LOAD) begin
            case (w.side)
                SIDE_LEFT:   left_store[w.position] = w.sample;
                SIDE_UP:     up_store[w.position]   = w.sample;
                SIDE_CORNER: corner_store           = w.sample;
                default: ;
            endcase
        end else if (predict_pixel(w, px)) begin
            pending_pixels.push_back(typed ? typed_px : px);
        end
    endtask

    task automatic send_word(input t_in_word w, input bit typed = 1'b0,
                             input logic [SAMPLE_BITS-1:0] typed_px = '0);
        bit ignored;
        case (words_counted * 4 / ITEMS)
            0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1:       begin in_idle_pct = 83; out_stall_pct = 0;  end
            2:       begin in_idle_pct = 0;  out_stall_pct = 83; end
            default: begin in_idle_pct = 36; out_stall_pct = 36; end
        endcase
        while (idle_now(in_idle_pct)) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        apply_word(w, typed, typed_px);
        ignored = (w.operation == OP_LOAD) ? (w.side == 2'd3) : (w.mode > MODE_UR);
        if (ignored)
            dropped_sent++;
        else if (w.operation == OP_LOAD)
            loads_sent++;
        else
            predicts_sent++;
        if (!ignored)
            words_counted++;
    endtask

    function automatic int pick_log2();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 0;
        else if (r < 84)
            return $urandom_range(1, 4);
        else if (r < 96)
            return $urandom_range(5, 6);
        return 7;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(9))
            0:       return 0;
            1:       return SAMPLE_MAX;
            default: return $urandom_range(SAMPLE_MAX);
        endcase
    endfunction

    // receiver: check each pixel word, then draw the next ready
    initial begin
        t_out_word got;
        logic [SAMPLE_BITS-1:0] want;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got = out_if.data;
                pixels_seen++;
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d with nothing pending", got.pixel));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel !== want)
                        report_mismatch($sformatf("pixel got %0d want %0d", got.pixel, want));
                end
            end
            out_if.ready <= !idle_now(out_stall_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
                 pending_pixels.size());
        $display("intra_block_predictor regression: fail");
        $finish;
    end

    initial begin
        t_row rows[$];
        int lw;
        int lh;
        int span;
        int smp;
        int r;
        int c;
        logic [2:0] mode;

        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: reads only touch entries written above them
        rows.push_back('{mk_load(SIDE_LEFT, 0, 0), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_LEFT, 1, SAMPLE_MAX), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_UP, 0, SAMPLE_MAX), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_UP, 1, SAMPLE_MAX), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_CORNER, 0, 512), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_LEFT, 127, SAMPLE_MAX), 1'b0, '0});
        rows.push_back('{mk_load(SIDE_UP, 127, 0), 1'b0, '0});
        // side three must not touch left[1]
        rows.push_back('{mk_load(2'd3, 1, 0), 1'b0, '0});
        rows.push_back('{mk_pred(MODE_VER, 2, 2, 0, 0), 1'b1, 10'd1023});
        rows.push_back('{mk_pred(MODE_HOR, 2, 2, 0, 5), 1'b1, 10'd0});
        rows.push_back('{mk_pred(MODE_HOR, 2, 2, 1, 0), 1'b1, 10'd1023});
        rows.push_back('{mk_pred(MODE_DC, 1, 1, 0, 0), 1'b1, 10'd767});
        rows.push_back('{mk_pred(MODE_DC, 0, 0, 0, 0), 1'b1, 10'd512});
        rows.push_back('{mk_pred(MODE_DC, 1, 1, 1, 1), 1'b1, 10'd767});
        rows.push_back('{mk_pred(MODE_UL, 2, 2, 0, 0), 1'b1, 10'd512});
        rows.push_back('{mk_pred(MODE_UL, 2, 2, 1, 0), 1'b1, 10'd0});
        rows.push_back('{mk_pred(MODE_UL, 2, 2, 0, 1), 1'b1, 10'd1023});
        rows.push_back('{mk_pred(MODE_UR, 6, 6, 63, 63), 1'b1, 10'd511});
        rows.push_back('{mk_pred(3'd5, 2, 2, 0, 0), 1'b0, '0});
        rows.push_back('{mk_pred(3'd7, 7, 7, 63, 63), 1'b0, '0});
        rows.push_back('{mk_pred(MODE_VER, 7, 7, 63, 1), 1'b0, '0});
        // a left write must flush the cached dc value
        rows.push_back('{mk_load(SIDE_LEFT, 0, SAMPLE_MAX), 1'b0, '0});
        rows.push_back('{mk_pred(MODE_DC, 1, 1, 0, 0), 1'b1, 10'd1023});
        // tall block: sum exceeds the sample range and saturates
        rows.push_back('{mk_pred(MODE_DC, 0, 1, 0, 0), 1'b1, 10'd1023});
        rows.push_back('{mk_pred(MODE_DC, 1, 0, 0, 0), 1'b1, 10'd767});
        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed, rows[i].pixel);

        // fill every store entry so later reads always hit written samples
        for (int k = 0; k < STORE_DEPTH; k++) begin
            send_word(mk_load(SIDE_LEFT, k, $urandom_range(SAMPLE_MAX)));
            send_word(mk_load(SIDE_UP, k, $urandom_range(SAMPLE_MAX)));
        end
        send_word(mk_load(SIDE_CORNER, 0, rand_sample()));

        // per block: refresh some neighbours, then predict a run of pixels
        while (words_counted < ITEMS) begin
            lw   = pick_log2();
            lh   = pick_log2();
            span = 2 * ((lw > lh) ? (1 << lw) : (1 << lh));
            if (span > STORE_DEPTH)
                span = STORE_DEPTH;
            if ($urandom_range(11) == 0) begin
                // bright flood drives dc into saturation on tall blocks
                for (int k = 0; k < span; k++) begin
                    smp = $urandom_range(1) ? SAMPLE_MAX : $urandom_range(900, SAMPLE_MAX);
                    send_word(mk_load(SIDE_LEFT, k, smp));
                    send_word(mk_load(SIDE_UP, k, smp));
                end
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    send_word(mk_load(2'(($urandom_range(9) == 0) ? 3 : $urandom_range(2)),
                                      ($urandom_range(3) == 0) ? $urandom_range(127)
                                                                : $urandom_range(span - 1),
                                      rand_sample()));
                end
            end
            repeat ($urandom_range(1, 8)) begin
                mode = 3'(($urandom_range(11) == 0) ? $urandom_range(5, 7)
                                                    : $urandom_range(4));
                r = ($urandom_range(7) == 0) ? $urandom_range(63)
                                             : $urandom_range(((1 << lh) > 64 ? 64 : (1 << lh)) - 1);
                c = ($urandom_range(7) == 0) ? $urandom_range(63)
                                             : $urandom_range(((1 << lw) > 64 ? 64 : (1 << lw)) - 1);
                send_word(mk_pred(mode, lw, lh, r, c));
            end
        end
        in_if.valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d loads, %0d predicts, %0d ignored words in %0d cycles",
                 loads_sent, predicts_sent, dropped_sent, cycle_count);
        $display("checked %0d pixels over four handshake phases, %0d mismatches",
                 pixels_seen, error_count);
        if (error_count == 0)
            $display("intra_block_predictor regression: pass");
        else
            $display("intra_block_predictor regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ibp_pkg.sv
rtl/core/ibp_in_if.sv
rtl/core/ibp_out_if.sv
rtl/core/ibp_ctrl.sv
rtl/core/ibp_datapath.sv
rtl/core/intra_block_predictor.sv
tb/testbench.sv
